// ----- sv/stereo_damped_comb_reverb_defines.svh -----
// assertion macros shared by the reverb rtl
`ifndef STEREO_DAMPED_COMB_REVERB_DEFINES_SVH
`define STEREO_DAMPED_COMB_REVERB_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define SDCR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SDCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SDCR_ASSERT(label, clk, rst, prop, msg)
`define SDCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/sdcr_pkg.sv -----
`default_nettype none

package sdcr_pkg;

  // sample and coefficient widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int GAIN_REGS   = 4;
  localparam int GAIN_IDX_W  = 2;
  localparam int LEN_FIELD_W = 12;
  localparam int LEN_W       = LEN_FIELD_W + 1;
  localparam int LEN_REG_W   = 4 * LEN_FIELD_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = LEN_REG_W;

  // shared multiplier: signed operand, unsigned q0.16 coefficient, rounded result
  localparam int MUL_A_W  = 18;
  localparam int MUL_P_W  = MUL_A_W + COEF_W + 1;
  localparam int MUL_R_W  = MUL_P_W - 16;
  localparam int RND_HALF = 32768;

  // width of an add before saturation
  localparam int SUM_W = 20;
  localparam logic signed [SUM_W-1:0] SAT_HI = 20'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_LO = -20'sd32768;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DAMP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN3 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LLEN  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RLEN  = 3'd7;

  // register reset values
  localparam logic [COEF_W-1:0]    DAMP_RESET  = 16'd19661;
  localparam logic [COEF_W-1:0]    CROSS_RESET = 16'd6554;
  localparam logic [COEF_W-1:0]    GAIN_RESET  = 16'd49152;
  localparam logic [LEN_REG_W-1:0] LEN_RESET   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COEF_W-1:0]                 damping;
    logic [COEF_W-1:0]                 crossfeed;
    logic [GAIN_REGS-1:0][COEF_W-1:0]  gain;
    logic [LEN_REG_W-1:0]              left_len;
    logic [LEN_REG_W-1:0]              right_len;
    logic                              clear;
  } cfg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/stereo_damped_comb_reverb.sv -----
`default_nettype none
// sequencing: one stereo pair at a time; in_stall holds the input until the previous pair's
//   output is loaded; each line takes eight sequencer slots, six of them products on the
//   single shared multiplier, both sides
// reset: synchronous; registers return to defaults, damping states and positions clear,
//   and per-line wrap flags mask the delay memories until each line has been rewritten,
//   so no memory clearing pass is needed

`include "stereo_damped_comb_reverb_defines.svh"

module stereo_damped_comb_reverb
  import sdcr_pkg::*;
#(
  parameter int LINE_COUNT = 4,
  parameter int LINE_DEPTH = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] left_in,
  input  wire logic signed [SAMPLE_W-1:0] right_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed      [SAMPLE_W-1:0] left_out,
  output logic signed      [SAMPLE_W-1:0] right_out,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int LINE_W  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int POS_W   = $clog2(LINE_DEPTH);
  localparam int STORE_D = LINE_COUNT * LINE_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_D);
  localparam int ACC_W   = SAMPLE_W + $clog2(LINE_COUNT);
  localparam int U_W     = ACC_W + 1;
  localparam int DIV_SH  = U_W + 2;
  localparam int RECIP   = (2 ** DIV_SH + LINE_COUNT - 1) / LINE_COUNT;
  localparam int DPROD_W = U_W + DIV_SH + 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_DL   = 4'd2;
  localparam logic [3:0] ST_DR   = 4'd3;
  localparam logic [3:0] ST_XL   = 4'd4;
  localparam logic [3:0] ST_XR   = 4'd5;
  localparam logic [3:0] ST_FL   = 4'd6;
  localparam logic [3:0] ST_FR   = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  cfg_t cfg;

  logic [3:0]        state;
  logic [LINE_W-1:0] line;
  logic              last_line;

  logic signed [SAMPLE_W-1:0] lin;
  logic signed [SAMPLE_W-1:0] rin;
  logic signed [SAMPLE_W-1:0] ls;
  logic signed [SAMPLE_W-1:0] rs;
  logic signed [MUL_A_W-1:0]  ml;
  logic signed [MUL_A_W-1:0]  mr;
  logic signed [SAMPLE_W-1:0] wr;
  logic signed [ACC_W-1:0]    lsum;
  logic signed [ACC_W-1:0]    rsum;

  logic signed [SAMPLE_W-1:0] lstate [LINE_COUNT];
  logic signed [SAMPLE_W-1:0] rstate [LINE_COUNT];
  logic        [POS_W-1:0]    lpos   [LINE_COUNT];
  logic        [POS_W-1:0]    rpos   [LINE_COUNT];
  logic        [LINE_COUNT-1:0] llap;
  logic        [LINE_COUNT-1:0] rlap;

  logic [LEN_FIELD_W-1:0] lfield;
  logic [LEN_FIELD_W-1:0] rfield;
  logic [LEN_W-1:0]       llen_raw;
  logic [LEN_W-1:0]       rlen_raw;
  logic [LEN_W-1:0]       llen;
  logic [LEN_W-1:0]       rlen;
  logic [POS_W-1:0]       lp;
  logic [POS_W-1:0]       rp;
  logic [LEN_W-1:0]       lp_inc;
  logic [LEN_W-1:0]       rp_inc;
  logic                   lwrap;
  logic                   rwrap;
  logic [ADDR_W-1:0]      laddr;
  logic [ADDR_W-1:0]      raddr;

  logic [SAMPLE_W-1:0]        l_rdata;
  logic [SAMPLE_W-1:0]        r_rdata;
  logic signed [SAMPLE_W-1:0] ld_val;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic                       ram_re;
  logic                       ram_we;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic        [COEF_W-1:0]   mul_b;
  logic signed [MUL_R_W-1:0]  mul_r;
  logic        [COEF_W-1:0]   gain_sel;

  logic signed [SAMPLE_W-1:0] ls_new;
  logic signed [SAMPLE_W-1:0] rs_new;
  logic signed [SAMPLE_W-1:0] wl;

  logic [U_W-1:0]     lu;
  logic [U_W-1:0]     ru;
  logic [DPROD_W-1:0] lq;
  logic [DPROD_W-1:0] rq;
  logic               out_load;

  sdcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // line length, clamped position and memory address for the current line
  always_comb begin
    lfield   = cfg.left_len[LEN_FIELD_W*line +: LEN_FIELD_W];
    rfield   = cfg.right_len[LEN_FIELD_W*line +: LEN_FIELD_W];
    llen_raw = LEN_W'(lfield) + LEN_W'(1);
    rlen_raw = LEN_W'(rfield) + LEN_W'(1);
    llen     = (llen_raw > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : llen_raw;
    rlen     = (rlen_raw > LEN_W'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : rlen_raw;
    lp       = (LEN_W'(lpos[line]) < llen) ? lpos[line] : '0;
    rp       = (LEN_W'(rpos[line]) < rlen) ? rpos[line] : '0;
    lp_inc   = LEN_W'(lp) + LEN_W'(1);
    rp_inc   = LEN_W'(rp) + LEN_W'(1);
    lwrap    = (lp_inc >= llen);
    rwrap    = (rp_inc >= rlen);
    laddr    = ADDR_W'(line) * ADDR_W'(LINE_DEPTH) + ADDR_W'(lp);
    raddr    = ADDR_W'(line) * ADDR_W'(LINE_DEPTH) + ADDR_W'(rp);
    last_line = (line == LINE_W'(LINE_COUNT - 1));
    gain_sel = cfg.gain[GAIN_IDX_W'(line)];
  end

  // entries of a line that has not yet wrapped since clear read as zero
  always_comb begin
    ld_val = llap[line] ? $signed(l_rdata) : '0;
    rd_val = rlap[line] ? $signed(r_rdata) : '0;
    ram_re = (state == ST_READ);
    ram_we = (state == ST_WR);
  end

  sdcr_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_D)) u_lram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (laddr),
    .wdata (wl),
    .re    (ram_re),
    .raddr (laddr),
    .rdata (l_rdata)
  );

  sdcr_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_D)) u_rram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (raddr),
    .wdata (wr),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (r_rdata)
  );

  // shared multiplier operand select, one product per slot
  always_comb begin
    case (state)
      ST_DL: begin
        mul_a = MUL_A_W'(ld_val) - MUL_A_W'(lstate[line]);
        mul_b = cfg.damping;
      end
      ST_DR: begin
        mul_a = MUL_A_W'(rd_val) - MUL_A_W'(rstate[line]);
        mul_b = cfg.damping;
      end
      ST_XL: begin
        mul_a = MUL_A_W'(ls);
        mul_b = cfg.crossfeed;
      end
      ST_XR: begin
        mul_a = MUL_A_W'(rs);
        mul_b = cfg.crossfeed;
      end
      ST_FL: begin
        mul_a = mr;
        mul_b = gain_sel;
      end
      ST_FR: begin
        mul_a = ml;
        mul_b = gain_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sdcr_mulrnd u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .result (mul_r)
  );

  // post-multiply adds with saturation
  always_comb begin
    ls_new = sat16(SUM_W'(lstate[line]) + SUM_W'(mul_r));
    rs_new = sat16(SUM_W'(rstate[line]) + SUM_W'(mul_r));
    wl     = sat16(SUM_W'(lin) + SUM_W'(mul_r));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      line  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_READ;
            line  <= '0;
          end
        end
        ST_READ: state <= ST_DL;
        ST_DL:   state <= ST_DR;
        ST_DR:   state <= ST_XL;
        ST_XL:   state <= ST_XR;
        ST_XR:   state <= ST_FL;
        ST_FL:   state <= ST_FR;
        ST_FR:   state <= ST_WR;
        ST_WR: begin
          if (last_line) begin
            state <= ST_OUT;
          end else begin
            state <= ST_READ;
            line  <= line + LINE_W'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers of the current beat
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lin  <= left_in;
        rin  <= right_in;
        lsum <= '0;
        rsum <= '0;
      end
      ST_DL: begin
        lsum <= lsum + ACC_W'(ld_val);
        rsum <= rsum + ACC_W'(rd_val);
      end
      ST_DR: ls <= ls_new;
      ST_XL: rs <= rs_new;
      ST_XR: mr <= MUL_A_W'(rs) + MUL_A_W'(mul_r);
      ST_FL: ml <= MUL_A_W'(ls) + MUL_A_W'(mul_r);
      ST_FR: wr <= sat16(SUM_W'(rin) + SUM_W'(mul_r));
      default: ;
    endcase
  end

  // per-line damping state, position and wrap flags
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      for (int k = 0; k < LINE_COUNT; k++) begin
        lstate[k] <= '0;
        rstate[k] <= '0;
        lpos[k]   <= '0;
        rpos[k]   <= '0;
      end
      llap <= '0;
      rlap <= '0;
    end else begin
      case (state)
        ST_DR: lstate[line] <= ls_new;
        ST_XL: rstate[line] <= rs_new;
        ST_WR: begin
          lpos[line] <= lwrap ? '0 : lp_inc[POS_W-1:0];
          rpos[line] <= rwrap ? '0 : rp_inc[POS_W-1:0];
          if (lwrap) begin
            llap[line] <= 1'b1;
          end
          if (rwrap) begin
            rlap[line] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // mean of the delayed reads: floor division by reciprocal multiply
  always_comb begin
    lu       = U_W'(lsum) + U_W'(LINE_COUNT * 65536);
    ru       = U_W'(rsum) + U_W'(LINE_COUNT * 65536);
    lq       = DPROD_W'(lu) * DPROD_W'(RECIP);
    rq       = DPROD_W'(ru) * DPROD_W'(RECIP);
    out_load = (state == ST_OUT) && (!out_valid || !out_stall);
    in_stall = (state != ST_IDLE);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= lq[DIV_SH +: SAMPLE_W];
      right_out <= rq[DIV_SH +: SAMPLE_W];
    end
  end

  `SDCR_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall, state == ST_READ && line == '0, "accepted beat did not start at line zero")
  `SDCR_ASSERT(a_out_from_seq, clk, rst, $rose(out_valid) |-> $past(state) == ST_OUT, "output valid rose outside the output slot")
  `SDCR_ASSERT_NEXT(a_clear_wipes, clk, rst, cfg.clear, llap == '0 && rlap == '0, "length write left wrap flags set")
  `SDCR_ASSERT(a_out_after_write, clk, rst, state == ST_OUT |-> $past(state) == ST_WR || $past(state) == ST_OUT, "output slot reached without last line write")

endmodule

`default_nettype wire

// ----- sv/sdcr_ram.sv -----
`default_nettype none

module sdcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/sdcr_mulrnd.sv -----
`default_nettype none

module sdcr_mulrnd
  import sdcr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic        [COEF_W-1:0]  b,
  output logic signed      [MUL_R_W-1:0] result
);

  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] prod_rnd;

  // signed sample times unsigned q0.16, rounded to nearest with ties up
  always_comb begin
    prod     = MUL_P_W'(a) * MUL_P_W'($signed({1'b0, b}));
    prod_rnd = prod + MUL_P_W'(RND_HALF);
  end

  always_ff @(posedge clk) begin
    result <= prod_rnd[MUL_P_W-1:16];
  end

endmodule

`default_nettype wire

// ----- sv/sdcr_cfg.sv -----
`default_nettype none

module sdcr_cfg
  import sdcr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  logic [COEF_W-1:0]                damping;
  logic [COEF_W-1:0]                crossfeed;
  logic [GAIN_REGS-1:0][COEF_W-1:0] gain;
  logic [LEN_REG_W-1:0]             left_len;
  logic [LEN_REG_W-1:0]             right_len;

  // register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      damping   <= DAMP_RESET;
      crossfeed <= CROSS_RESET;
      gain      <= {GAIN_REGS{GAIN_RESET}};
      left_len  <= LEN_RESET;
      right_len <= LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DAMP:  damping   <= cfg_data[COEF_W-1:0];
        REG_CROSS: crossfeed <= cfg_data[COEF_W-1:0];
        REG_GAIN0: gain[0]   <= cfg_data[COEF_W-1:0];
        REG_GAIN1: gain[1]   <= cfg_data[COEF_W-1:0];
        REG_GAIN2: gain[2]   <= cfg_data[COEF_W-1:0];
        REG_GAIN3: gain[3]   <= cfg_data[COEF_W-1:0];
        REG_LLEN:  left_len  <= cfg_data[LEN_REG_W-1:0];
        REG_RLEN:  right_len <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // a length write wipes all line state
  always_comb begin
    cfg.damping   = damping;
    cfg.crossfeed = crossfeed;
    cfg.gain      = gain;
    cfg.left_len  = left_len;
    cfg.right_len = right_len;
    cfg.clear     = cfg_write && (cfg_index == REG_LLEN || cfg_index == REG_RLEN);
  end

endmodule

`default_nettype wire
